FILE: rtl/timed_key_tap_injector_core_defines.svh
// Assertion macros for the tap injector.
`ifndef TIMED_KEY_TAP_INJECTOR_CORE_DEFINES_SVH
`define TIMED_KEY_TAP_INJECTOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TKTI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TKTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tkti_pkg.sv
`timescale 1ns / 1ps
package tkti_pkg;

  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_SERVICE = 1'b1;

  localparam logic REG_HOLD_TICKS = 1'b0;
  localparam logic REG_GAP_TICKS  = 1'b1;

  localparam logic [15:0] HOLD_TICKS_RESET = 16'd90;
  localparam logic [15:0] GAP_TICKS_RESET  = 16'd20;

  typedef struct packed {
    logic        req_type;
    logic [31:0] now_tick;
    logic [7:0]  tap_modifier;
    logic [7:0]  tap_usage;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       report_valid;
    logic [7:0] report_modifier;
    logic [7:0] report_usage;
    logic [5:0] pending_count;
    logic       is_last;
  } out_item_t;

  // Decoded request handed from the front to the back.
  typedef struct packed {
    logic        is_enq;
    logic        usage_ok;
    logic [31:0] now_tick;
    logic [7:0]  tap_modifier;
    logic [7:0]  tap_usage;
  } cmd_t;

  typedef struct packed {
    logic [15:0] hold_ticks;
    logic [15:0] gap_ticks;
  } cfg_regs_t;

  // A deadline is reached when now - deadline, read as signed, is not negative.
  function automatic logic deadline_reached(logic [31:0] now, logic [31:0] deadline);
    logic [31:0] diff;
    diff = now - deadline;
    return ~diff[31];
  endfunction

endpackage

FILE: rtl/tkti_ram.sv
`timescale 1ns / 1ps
module tkti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/tkti_front.sv
`timescale 1ns / 1ps
module tkti_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tkti_pkg::in_item_t in_data,
  output logic              cmd_valid,
  output tkti_pkg::cmd_t    cmd,
  input  logic              cmd_pop
);
  import tkti_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_t       dec;

  always_comb begin
    dec.is_enq       = (in_data.req_type == REQ_ENQUEUE);
    dec.usage_ok     = (in_data.tap_usage != 8'd0);
    dec.now_tick     = in_data.now_tick;
    dec.tap_modifier = in_data.tap_modifier;
    dec.tap_usage    = in_data.tap_usage;
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

FILE: rtl/tkti_back.sv
`timescale 1ns / 1ps
module tkti_back #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  tkti_pkg::cmd_t       cmd,
  output logic                 cmd_pop,
  input  tkti_pkg::cfg_regs_t  cfg,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tkti_pkg::out_item_t  out_data
);
  import tkti_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SVC, ST_OUT} state_t;

  state_t      state_r, state_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic        held_r, held_nxt;
  logic [31:0] rdl_r, rdl_nxt;
  logic [31:0] pdl_r, pdl_nxt;
  logic        rel_r, rel_nxt;
  logic [31:0] now_r, now_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  out_item_t   pend_r, pend_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_rdata;
  logic [SW-1:0] wsum;
  logic          enq_ok;
  logic          rel;
  logic          press;
  out_item_t     rel_item, press_item, idle_item;

  tkti_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({cmd.tap_modifier, cmd.tap_usage}),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  // Slot behind the newest tap, wrapped at the ring depth.
  always_comb begin
    wsum = SW'(rp_r) + SW'(count_r);
    if (wsum >= SW'(QUEUE_DEPTH)) begin
      wsum = wsum - SW'(QUEUE_DEPTH);
    end
    ram_waddr = AW'(wsum);
  end

  assign enq_ok = cmd.usage_ok && (count_r < CW'(QUEUE_DEPTH));
  assign rel    = held_r && deadline_reached(cmd.now_tick, rdl_r);
  assign press  = !held_r && (count_r != '0) && deadline_reached(now_r, pdl_r);

  always_comb begin
    state_nxt      = state_r;
    rp_nxt         = rp_r;
    count_nxt      = count_r;
    held_nxt       = held_r;
    rdl_nxt        = rdl_r;
    pdl_nxt        = pdl_r;
    rel_nxt        = rel_r;
    now_nxt        = now_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    cmd_pop        = 1'b0;
    ram_we         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.is_enq) begin
            ram_we = enq_ok;
            if (enq_ok) begin
              count_nxt = count_r + CW'(1);
            end
            out_nxt.accepted        = enq_ok;
            out_nxt.report_valid    = 1'b0;
            out_nxt.report_modifier = 8'd0;
            out_nxt.report_usage    = 8'd0;
            out_nxt.pending_count   = 6'(count_nxt);
            out_nxt.is_last         = 1'b1;
            out_valid_nxt           = 1'b1;
            state_nxt               = ST_OUT;
          end else begin
            // Release first; the press check runs next cycle on the ring data.
            if (rel) begin
              held_nxt = 1'b0;
              pdl_nxt  = cmd.now_tick + 32'(cfg.gap_ticks);
            end
            rel_nxt   = rel;
            now_nxt   = cmd.now_tick;
            state_nxt = ST_SVC;
          end
        end
      end
      ST_SVC: begin
        if (press) begin
          rp_nxt    = (rp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + AW'(1);
          count_nxt = count_r - CW'(1);
          held_nxt  = 1'b1;
          rdl_nxt   = now_r + 32'(cfg.hold_ticks);
        end
        if (rel_r) begin
          out_nxt        = rel_item;
          pend_nxt       = press_item;
          pend_valid_nxt = press;
        end else if (press) begin
          out_nxt = press_item;
        end else begin
          out_nxt = idle_item;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (pend_valid_r) begin
            out_nxt        = pend_r;
            pend_valid_nxt = 1'b0;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rel_item.accepted        = 1'b0;
    rel_item.report_valid    = 1'b1;
    rel_item.report_modifier = 8'd0;
    rel_item.report_usage    = 8'd0;
    rel_item.pending_count   = 6'(count_nxt);
    rel_item.is_last         = !press;

    press_item.accepted        = 1'b0;
    press_item.report_valid    = 1'b1;
    press_item.report_modifier = ram_rdata[15:8];
    press_item.report_usage    = ram_rdata[7:0];
    press_item.pending_count   = 6'(count_nxt);
    press_item.is_last         = 1'b1;

    idle_item.accepted        = 1'b0;
    idle_item.report_valid    = 1'b0;
    idle_item.report_modifier = 8'd0;
    idle_item.report_usage    = 8'd0;
    idle_item.pending_count   = 6'(count_nxt);
    idle_item.is_last         = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rp_r         <= '0;
      count_r      <= '0;
      held_r       <= 1'b0;
      rdl_r        <= 32'd0;
      pdl_r        <= 32'd0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rp_r         <= rp_nxt;
      count_r      <= count_nxt;
      held_r       <= held_nxt;
      rdl_r        <= rdl_nxt;
      pdl_r        <= pdl_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
    rel_r  <= rel_nxt;
    now_r  <= now_nxt;
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/timed_key_tap_injector_core.sv
`timescale 1ns / 1ps
// Port group   Direction  Transfer
// in_*         input      request item on in_valid & !in_stall
// out_*        output     result item on out_valid & !out_stall
// p*           input      APB register write/read, pready tied high
//
// A 2-entry request queue in front takes a new item each cycle until full.
// The back sequencer handles one request at a time: an enqueue goes straight to
// the output state, a service passes through the service state first and may give
// a second result (release then press); the ring RAM's registered read sets that state.
// Reset (rst_n low, synchronous) empties the ring and restores hold 90, gap 20.
// A stalled result holds in the output register; the front keeps accepting until its queue is full.
module timed_key_tap_injector_core #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tkti_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tkti_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tkti_pkg::*;

  `include "timed_key_tap_injector_core_defines.svh"

  cfg_regs_t cfg_r;
  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;
  logic      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_ticks <= HOLD_TICKS_RESET;
      cfg_r.gap_ticks  <= GAP_TICKS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_HOLD_TICKS: cfg_r.hold_ticks <= pwdata[15:0];
        REG_GAP_TICKS:  cfg_r.gap_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HOLD_TICKS: prdata = {16'd0, cfg_r.hold_ticks};
      REG_GAP_TICKS:  prdata = {16'd0, cfg_r.gap_ticks};
      default:        prdata = 32'd0;
    endcase
  end

  tkti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tkti_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `TKTI_ASSERT_NEXT(a_one_cmd_at_a_time, cmd_pop, !cmd_pop, "back took two requests in a row")
  `TKTI_ASSERT_NOW(a_report_not_accepted, out_valid && out_data.report_valid, !out_data.accepted, "report result flagged as accepted")
  `TKTI_ASSERT_NOW(a_enq_single_result, out_valid && out_data.accepted, !out_data.report_valid && out_data.is_last, "enqueue result malformed")
  `TKTI_ASSERT_NOW(a_press_has_usage, out_valid && out_data.report_valid && (out_data.report_modifier != 8'd0), out_data.report_usage != 8'd0, "press report without usage")

endmodule

FILE: test/tkti_tap_monitor.sv
`timescale 1ns / 1ps
module tkti_tap_monitor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  tkti_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  tkti_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic [31:0]         prdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  reports_owed,
  output int                  press_seen,
  output int                  release_seen,
  output int                  pair_seen,
  output int                  refused_seen
);
  import tkti_pkg::*;

  localparam int RING_DEPTH = 32;

  logic [7:0]  mod_ring [RING_DEPTH];
  logic [7:0]  usage_ring [RING_DEPTH];
  logic [4:0]  head_ptr;
  logic [5:0]  tap_count;
  logic        key_down;
  logic [31:0] release_at;
  logic [31:0] press_at;
  logic [15:0] hold_ticks;
  logic [15:0] gap_ticks;

  out_item_t awaited_reports [$];

  initial begin
    fail_count   = 0;
    reports_owed = 0;
    press_seen   = 0;
    release_seen = 0;
    pair_seen    = 0;
    refused_seen = 0;
  end

  // Wrapping compare: reached once now is not behind the deadline.
  function automatic logic tick_passed(logic [31:0] now, logic [31:0] due);
    return $signed(now - due) >= 0;
  endfunction

  task automatic play_request(input in_item_t rq);
    out_item_t  res [2];
    int         n;
    logic [4:0] wr;
    n = 0;
    if (rq.req_type == REQ_ENQUEUE) begin
      res[0] = '0;
      if (rq.tap_usage != 8'd0 && tap_count < RING_DEPTH) begin
        wr = head_ptr + tap_count[4:0];
        mod_ring[wr]   = rq.tap_modifier;
        usage_ring[wr] = rq.tap_usage;
        tap_count      = tap_count + 6'd1;
        res[0].accepted = 1'b1;
      end else begin
        refused_seen++;
      end
      n = 1;
    end else begin
      if (key_down && tick_passed(rq.now_tick, release_at)) begin
        res[n] = '0;
        res[n].report_valid = 1'b1;
        n++;
        key_down = 1'b0;
        press_at = rq.now_tick + 32'(gap_ticks);
        release_seen++;
      end
      if (!key_down && tap_count != 6'd0 && tick_passed(rq.now_tick, press_at)) begin
        res[n] = '0;
        res[n].report_valid    = 1'b1;
        res[n].report_modifier = mod_ring[head_ptr];
        res[n].report_usage    = usage_ring[head_ptr];
        n++;
        head_ptr   = head_ptr + 5'd1;
        tap_count  = tap_count - 6'd1;
        key_down   = 1'b1;
        release_at = rq.now_tick + 32'(hold_ticks);
        press_seen++;
      end
      if (n == 2) pair_seen++;
      if (n == 0) begin
        res[0] = '0;
        n = 1;
      end
    end
    for (int k = 0; k < n; k++) begin
      res[k].pending_count = tap_count;
      res[k].is_last       = (k == n - 1);
      awaited_reports.push_back(res[k]);
    end
  endtask

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head_ptr   = '0;
      tap_count  = '0;
      key_down   = 1'b0;
      release_at = '0;
      press_at   = '0;
      hold_ticks = HOLD_TICKS_RESET;
      gap_ticks  = GAP_TICKS_RESET;
      awaited_reports.delete();
      reports_owed <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[2])
            REG_HOLD_TICKS: hold_ticks = pwdata[15:0];
            REG_GAP_TICKS:  gap_ticks  = pwdata[15:0];
            default: ;
          endcase
        end else begin
          case (paddr[2])
            REG_HOLD_TICKS: compare_field("hold_ticks readback", {16'd0, hold_ticks}, prdata);
            REG_GAP_TICKS:  compare_field("gap_ticks readback", {16'd0, gap_ticks}, prdata);
            default: ;
          endcase
        end
      end
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          $error("result item with nothing expected: %h", out_data);
          fail_count++;
        end else begin
          out_item_t want;
          want = awaited_reports.pop_front();
          compare_field("accepted", want.accepted, out_data.accepted);
          compare_field("report_valid", want.report_valid, out_data.report_valid);
          compare_field("report_modifier", want.report_modifier, out_data.report_modifier);
          compare_field("report_usage", want.report_usage, out_data.report_usage);
          compare_field("pending_count", want.pending_count, out_data.pending_count);
          compare_field("is_last", want.is_last, out_data.is_last);
        end
      end
      if (in_valid && !in_stall) play_request(in_data);
      reports_owed <= awaited_reports.size();
    end
  end

endmodule

FILE: test/timed_key_tap_injector_core_tb.sv
`timescale 1ns / 1ps
module timed_key_tap_injector_core_tb;
  import tkti_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int reports_owed;
  int press_seen;
  int release_seen;
  int pair_seen;
  int refused_seen;

  int          cycle_count = 0;
  int          req_count = 0;
  int          setting_count = 0;
  int          stall_left = 0;
  int          stall_draw;
  logic        calm = 1'b0;
  logic [31:0] tick = '0;
  int          step_max = 8;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  timed_key_tap_injector_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tkti_tap_monitor u_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .reports_owed(reports_owed),
    .press_seen  (press_seen),
    .release_seen(release_seen),
    .pair_seen   (pair_seen),
    .refused_seen(refused_seen)
  );

  // Result side: stall for a random number of cycles after each item.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      stall_draw = calm ? 0 : $urandom_range(0, 3);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** timed_key_tap_injector_core: FAILED **");
      $finish;
    end
  end

  task automatic push_req(input in_item_t item);
    int idle;
    idle = calm ? 0 : $urandom_range(0, 3);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    req_count++;
  endtask

  task automatic send_tap(input logic [7:0] modifier, input logic [7:0] usage);
    in_item_t item;
    item.req_type     = REQ_ENQUEUE;
    item.now_tick     = $urandom;
    item.tap_modifier = modifier;
    item.tap_usage    = usage;
    push_req(item);
  endtask

  task automatic send_service(input logic [31:0] now);
    in_item_t item;
    item.req_type     = REQ_SERVICE;
    item.now_tick     = now;
    item.tap_modifier = 8'($urandom);
    item.tap_usage    = 8'($urandom);
    push_req(item);
  endtask

  task automatic cfg_access(input logic wr, input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Idle the request side, let every owed result drain, then retime.
  task automatic set_timing(input logic [15:0] hold, input logic [15:0] gap);
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_access(1'b1, REG_HOLD_TICKS, {16'($urandom), hold});
    cfg_access(1'b1, REG_GAP_TICKS, {16'($urandom), gap});
    cfg_access(1'b0, REG_HOLD_TICKS, '0);
    cfg_access(1'b0, REG_GAP_TICKS, '0);
    step_max = ((hold > gap) ? hold : gap) / 6 + 8;
    tick = tick + 32'd200000;
    setting_count++;
  endtask

  task automatic run_random(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        send_tap(8'($urandom),
                 ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
      end else if (pick < 95) begin
        tick = tick + 32'($urandom_range(0, step_max));
        send_service(tick);
      end else if (pick < 98) begin
        // Jump the clock forward; keeps deadlines reachable.
        tick = tick + 32'($urandom_range(1, 1 << 29));
        send_service(tick);
      end else begin
        // Stale tick slightly in the past.
        send_service(tick - 32'($urandom_range(1, 5000)));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default timing: hold 90, gap 20.
    send_service(32'd0);
    send_tap(8'hA5, 8'h00);
    send_tap(8'hFF, 8'hFF);
    send_tap(8'h00, 8'h01);
    send_tap(8'h5A, 8'h80);
    send_service(32'd0);
    send_service(32'd89);
    send_service(32'd90);
    send_service(32'd109);
    send_service(32'd110);
    send_service(32'h8000_00C8);
    send_service(32'd200);
    send_service(32'hFFFF_FFFF);
    send_service(32'd220);
    tick = 32'd400;
    run_random(250);

    // Zero hold and gap: release and press in one step.
    set_timing(16'd0, 16'd0);
    send_tap(8'h01, 8'h04);
    send_tap(8'h02, 8'h05);
    send_service(tick);
    send_service(tick);
    send_service(tick);
    run_random(200);

    // Longest timing; burst of taps overflows the ring.
    set_timing(16'hFFFF, 16'hFFFF);
    repeat (34) send_tap(8'($urandom), 8'($urandom_range(1, 255)));
    run_random(150);

    set_timing(16'd1, 16'd0);
    run_random(200);

    set_timing(16'd0, 16'hFFFF);
    run_random(150);

    set_timing(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)));
    run_random(270);

    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d requests over %0d timing settings plus reset values.",
             req_count, setting_count);
    $display("Saw %0d presses, %0d releases, %0d release-press steps, %0d refused taps.",
             press_seen, release_seen, pair_seen, refused_seen);
    if (fail_count == 0) begin
      $display("** timed_key_tap_injector_core: PASSED **");
    end else begin
      $display("** timed_key_tap_injector_core: FAILED **");
    end
    $finish;
  end

endmodule
